// File: hdl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared widths and types for the full cross-correlation block.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // sequence lengths (0..32) and lag positions (0..62)
  localparam int LEN_W   = 6;
  localparam int LAG_W   = 6;
  localparam int VALUE_W = 36;

  // loader status seen by the correlation engine
  typedef struct packed {
    logic             run;    // both sequences closed
    logic             trunc;  // a sample was dropped in this run
    logic [LEN_W-1:0] n1;
    logic [LEN_W-1:0] n2;
  } load_status_t;

endpackage

// File: hdl/fcc_in_if.sv
// ----------------------------------------------------------------------------
// fcc_in_if
// Sample channel: valid/ready handshake carrying one sample item.
// ----------------------------------------------------------------------------
interface fcc_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, kind, sample, last, input ready);
  modport sink   (input valid, kind, sample, last, output ready);
endinterface

// File: hdl/fcc_out_if.sv
// ----------------------------------------------------------------------------
// fcc_out_if
// Result channel: valid/ready handshake carrying one correlation lag item.
// ----------------------------------------------------------------------------
interface fcc_out_if ();
  logic               valid;
  logic               ready;
  logic [5:0]         lag_index;
  logic signed [35:0] value;
  logic               end_of_run;
  logic               truncated;

  modport source (output valid, lag_index, value, end_of_run, truncated, input ready);
  modport sink   (input valid, lag_index, value, end_of_run, truncated, output ready);
endinterface

// File: hdl/fcc_ram.sv
// ----------------------------------------------------------------------------
// fcc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fcc_loader.sv
// ----------------------------------------------------------------------------
// fcc_loader
// Takes sample items, writes them into the two sample RAMs and tracks
// lengths, closed flags and the dropped-sample flag.
// ----------------------------------------------------------------------------
module fcc_loader #(
  parameter int MAX_LEN     = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  fcc_in_if.sink                                      in_i,
  input  logic                                        clear_i,
  output fcc_pkg::load_status_t                       status_o,
  output logic                                        we_a_o,
  output logic                                        we_b_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] waddr_o,
  output logic [SAMPLE_BITS-1:0]                      wdata_o
);
  import fcc_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [LEN_W-1:0] n1_q, n1_d, n2_q, n2_d;
  logic             c1_q, c1_d, c2_q, c2_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             run;

  assign run      = c1_q & c2_q;
  assign in_i.ready = ~run;
  assign accept   = in_i.valid & ~run;

  always_comb begin
    n1_d    = n1_q;
    n2_d    = n2_q;
    c1_d    = c1_q;
    c2_d    = c2_q;
    ovf_d   = ovf_q;
    we_a_o  = 1'b0;
    we_b_o  = 1'b0;
    waddr_o = n1_q[AW-1:0];
    if (clear_i) begin
      n1_d  = '0;
      n2_d  = '0;
      c1_d  = 1'b0;
      c2_d  = 1'b0;
      ovf_d = 1'b0;
    end else if (accept) begin
      if (!in_i.kind && !c1_q) begin
        if (n1_q < LEN_W'(MAX_LEN)) begin
          we_a_o = 1'b1;
          n1_d   = n1_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        c1_d = in_i.last;
      end else if (in_i.kind && !c2_q) begin
        waddr_o = n2_q[AW-1:0];
        if (n2_q < LEN_W'(MAX_LEN)) begin
          we_b_o = 1'b1;
          n2_d   = n2_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        c2_d = in_i.last;
      end
    end
  end

  assign wdata_o = in_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q  <= '0;
      n2_q  <= '0;
      c1_q  <= 1'b0;
      c2_q  <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      n1_q  <= n1_d;
      n2_q  <= n2_d;
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      ovf_q <= ovf_d;
    end
  end

  assign status_o.run   = run;
  assign status_o.trunc = ovf_q;
  assign status_o.n1    = n1_q;
  assign status_o.n2    = n2_q;

  a_one_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_a_o && we_b_o))
    else $error("sample written to both RAMs");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n1_q <= LEN_W'(MAX_LEN)) && (n2_q <= LEN_W'(MAX_LEN)))
    else $error("sequence length beyond capacity");

  a_no_write_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> !(we_a_o || we_b_o))
    else $error("RAM written while a run is pending");

endmodule

// File: hdl/fcc_engine.sv
// ----------------------------------------------------------------------------
// fcc_engine
// Lag sequencer with a read / multiply / accumulate pipeline over the two
// sample RAMs, saturation and the result output register.
// ----------------------------------------------------------------------------
module fcc_engine #(
  parameter int MAX_LEN     = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  fcc_pkg::load_status_t                       status_i,
  output logic                                        clear_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] raddr_a_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] raddr_b_o,
  input  logic [SAMPLE_BITS-1:0]                      rdata_a_i,
  input  logic [SAMPLE_BITS-1:0]                      rdata_b_i,
  fcc_out_if.source                                   res_o
);
  import fcc_pkg::*;

  localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = 2 * SAMPLE_BITS + 6;
  localparam int SUM_W  = (ACC_W > VALUE_W + 1) ? ACC_W : VALUE_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [LAG_W-1:0] i_q, i_d;
  logic [LEN_W-1:0] k_q, k_d, j_q, j_d, kend_q, kend_d;
  logic             first_q, first_d;

  logic issue, term_last, run_last, out_load;

  // pipeline: stage 1 = RAM data, stage 2 = product, then accumulator
  logic                     p1_v_q, p1_first_q, p1_last_q;
  logic                     p2_v_q, p2_first_q, p2_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  prod_ext;
  logic                     done_q;

  logic [VALUE_W-1:0] sat_value;
  logic [SUM_W-VALUE_W:0] acc_hi;

  logic                     out_valid_q, out_valid_d;
  logic [LAG_W-1:0]         out_lag_q;
  logic [VALUE_W-1:0]       out_value_q;
  logic                     out_end_q, out_trunc_q;

  assign term_last = (k_q == kend_q);
  assign run_last  = (i_q == LAG_W'(status_i.n1 + status_i.n2 - 2'd2));
  assign out_load  = (state_q == S_EMIT) && (!out_valid_q || res_o.ready);
  assign issue     = (state_q == S_ISSUE);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    k_d     = k_q;
    j_d     = j_q;
    kend_d  = kend_q;
    first_d = first_q;
    clear_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        i_d = '0;
        if (status_i.run) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        // term range of lag i: k in [max(0,i-n2+1), min(n1-1,i)], j = k+n2-1-i
        k_d     = (i_q >= status_i.n2) ? (i_q - status_i.n2 + 1'b1) : '0;
        j_d     = (i_q < status_i.n2) ? (status_i.n2 - 1'b1 - i_q) : '0;
        kend_d  = (i_q < status_i.n1) ? i_q : (status_i.n1 - 1'b1);
        first_d = 1'b1;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        k_d     = k_q + 1'b1;
        j_d     = j_q + 1'b1;
        first_d = 1'b0;
        if (term_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (done_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (run_last) begin
            clear_o = 1'b1;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_SETUP;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign raddr_a_o = k_q[AW-1:0];
  assign raddr_b_o = j_q[AW-1:0];

  assign prod_ext = SUM_W'(prod_q);

  // clamp the wide sum to the 36-bit result range
  assign acc_hi = acc_q[SUM_W-1:VALUE_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_value = acc_q[VALUE_W-1:0];
    end else if (acc_q[SUM_W-1]) begin
      sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      k_q         <= '0;
      j_q         <= '0;
      kend_q      <= '0;
      first_q     <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      j_q         <= j_d;
      kend_q      <= kend_d;
      first_q     <= first_d;
      p1_v_q      <= issue;
      p2_v_q      <= p1_v_q;
      done_q      <= p2_v_q & p2_last_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_first_q <= first_q;
    p1_last_q  <= term_last;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    if (p1_v_q) begin
      prod_q <= $signed(rdata_a_i) * $signed(rdata_b_i);
    end
    if (p2_v_q) begin
      acc_q <= p2_first_q ? prod_ext : (acc_q + prod_ext);
    end
    if (out_load) begin
      out_lag_q   <= i_q;
      out_value_q <= sat_value;
      out_end_q   <= run_last;
      out_trunc_q <= status_i.trunc;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.lag_index  = out_lag_q;
  assign res_o.value      = out_value_q;
  assign res_o.end_of_run = out_end_q;
  assign res_o.truncated  = out_trunc_q;

  a_issue_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> status_i.run)
    else $error("term issued with no run pending");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (k_q <= kend_q) && (j_q < status_i.n2))
    else $error("term index out of range");

  a_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_DRAIN))
    else $error("lag sum finished outside drain");

  a_clear_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_o |=> (out_valid_q && out_end_q))
    else $error("run cleared without its final lag");

endmodule

// File: hdl/full_cross_correlation.sv
// ----------------------------------------------------------------------------
// full_cross_correlation
// Full discrete cross-correlation of two signed sample sequences.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries sample items (kind, sample, last). kind 0 loads the first
//   sequence, kind 1 the second; they may interleave. A set last flag closes
//   that sequence. Samples past MAX_LEN are dropped and flag the run as
//   truncated; items for an already closed sequence are taken and ignored.
//   Once both sequences are closed, in_i.ready drops and the block emits
//   n1+n2-1 lag items on res_o, lag 0 (most negative) first, end_of_run on
//   the final one. It then clears both sequences and takes samples again.
//   Loading: one item per cycle while no run is pending. Each lag runs setup,
//   then RAM read, multiply, accumulate and output for its terms, one multiply-
//   accumulate per cycle through the single read port of each sample RAM.
//   A stalled receiver holds the output register; the next lag is computed
//   meanwhile and waits. Reset (rst_ni low) empties both sequences.
// ----------------------------------------------------------------------------
module full_cross_correlation #(
  parameter int MAX_LEN     = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcc_in_if.sink     in_i,
  fcc_out_if.source  res_o
);
  import fcc_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  load_status_t           status;
  logic                   clear;
  logic                   we_a, we_b;
  logic [AW-1:0]          waddr, raddr_a, raddr_b;
  logic [SAMPLE_BITS-1:0] wdata, rdata_a, rdata_b;

  fcc_loader #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_loader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .clear_i  (clear),
    .status_o (status),
    .we_a_o   (we_a),
    .we_b_o   (we_b),
    .waddr_o  (waddr),
    .wdata_o  (wdata)
  );

  fcc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_ram_first (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  fcc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_ram_second (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  fcc_engine #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .status_i  (status),
    .clear_o   (clear),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .res_o     (res_o)
  );

endmodule

// File: tb/tb_full_cross_correlation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_full_cross_correlation
// Self-checking bench for the full cross-correlation block: loads pairs of
// sample sequences over the sample channel and checks every lag item against
// a behavioral correlator, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_full_cross_correlation;
  import fcc_pkg::*;

  localparam int MAX_LEN      = 32;
  localparam int SAMPLE_BITS  = 16;
  localparam int RANDOM_ITEMS = 250;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic KIND_FIRST  = 1'b0;
  localparam logic KIND_SECOND = 1'b1;

  localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;

  typedef enum int {FILL_RANDOM, FILL_SMALL, FILL_EXTREME, FILL_MIN} fill_e;

  typedef struct {
    logic                   kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    bit                     hold;   // wait for all pending lags before sending
  } sample_item_t;

  typedef struct packed {
    logic [LAG_W-1:0]          lag;
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_run;
    logic                      truncated;
  } lag_result_t;

  logic clk_i;
  logic rst_ni;

  fcc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
  fcc_out_if lag_if ();

  full_cross_correlation #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (smp_if),
    .res_o (lag_if)
  );

  sample_item_t sample_q[$];
  lag_result_t  lag_expect_q[$];
  int           errors;
  int           items_total;
  int           items_taken;

  // correlator state
  logic signed [SAMPLE_BITS-1:0] seq_a[MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] seq_b[MAX_LEN];
  int len_a, len_b;
  bit closed_a, closed_b, dropped;

  // idling state
  int in_gap, in_calm, out_gap, out_calm;
  bit next_valid;
  bit lag_taken;
  int idle_cycles;
  sample_item_t cur_item;
  lag_result_t  want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // correlator: consumes one accepted sample item, queues the lags it causes
  // --------------------------------------------------------------------------
  task automatic take_sample(input logic kind, input logic [SAMPLE_BITS-1:0] raw,
                             input logic last_flag);
    int n, i, k, j;
    longint sum;
    lag_result_t r;
    if (kind == KIND_FIRST) begin
      if (!closed_a) begin
        if (len_a < MAX_LEN) begin
          seq_a[len_a] = raw;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
        if (last_flag) closed_a = 1'b1;
      end
    end else begin
      if (!closed_b) begin
        if (len_b < MAX_LEN) begin
          seq_b[len_b] = raw;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
        if (last_flag) closed_b = 1'b1;
      end
    end
    if (closed_a && closed_b) begin
      n = len_a + len_b - 1;
      for (i = 0; i < n; i++) begin
        sum = 0;
        // lag i-(len_b-1): first[k] against second[k - lag]
        for (k = 0; k < len_a; k++) begin
          j = len_b - 1 - i + k;
          if (j >= 0 && j < len_b) sum += longint'(seq_a[k]) * longint'(seq_b[j]);
        end
        if (sum > VALUE_MAX) sum = VALUE_MAX;
        if (sum < VALUE_MIN) sum = VALUE_MIN;
        r.lag        = i[LAG_W-1:0];
        r.value      = sum[VALUE_W-1:0];
        r.end_of_run = (i == n - 1);
        r.truncated  = dropped;
        lag_expect_q.push_back(r);
      end
      len_a    = 0;
      len_b    = 0;
      closed_a = 1'b0;
      closed_b = 1'b0;
      dropped  = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input fill_e fill);
    logic [SAMPLE_BITS-1:0] s;
    case (fill)
      FILL_SMALL: s = SAMPLE_BITS'($urandom_range(0, 15) - 8);
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       s = 16'h8000;
          1:       s = 16'h7FFF;
          2:       s = 16'hFFFF;
          3:       s = 16'h0001;
          default: s = 16'h0000;
        endcase
      end
      FILL_MIN: s = 16'h8000;
      default:  s = SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
    return s;
  endfunction

  task automatic push_item(input logic kind, input logic [SAMPLE_BITS-1:0] s,
                           input logic last_flag, input bit hold);
    sample_item_t it;
    it.kind   = kind;
    it.sample = s;
    it.last   = last_flag;
    it.hold   = hold;
    sample_q.push_back(it);
  endtask

  // Two sequences of n1 and n2 samples, randomly interleaved; lengths past
  // MAX_LEN overflow and the closing sample is then a dropped one. While one
  // side is closed, stray samples for it are sometimes slipped in.
  task automatic queue_pair(input int n1, input int n2, input fill_e fill,
                            input bit hold);
    int ia, ib;
    bit lead;
    ia = 0;
    ib = 0;
    lead = hold;
    while (ia < n1 || ib < n2) begin
      if ((ia == n1 || ib == n2) && $urandom_range(0, 9) == 0) begin
        push_item((ia == n1) ? KIND_FIRST : KIND_SECOND, pick_sample(FILL_RANDOM),
                  1'($urandom_range(0, 1)), lead);
        lead = 1'b0;
      end
      if (ia < n1 && (ib == n2 || $urandom_range(0, 1) == 1)) begin
        push_item(KIND_FIRST, pick_sample(fill), ia == n1 - 1, lead);
        ia++;
      end else begin
        push_item(KIND_SECOND, pick_sample(fill), ib == n2 - 1, lead);
        ib++;
      end
      lead = 1'b0;
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 93) return $urandom_range(9, MAX_LEN - 1);
    if (r < 97) return MAX_LEN;
    return $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
  endfunction

  function automatic fill_e pick_fill();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return FILL_RANDOM;
    if (r < 80) return FILL_SMALL;
    if (r < 95) return FILL_EXTREME;
    return FILL_MIN;
  endfunction

  // --------------------------------------------------------------------------
  // sample driver; the correlator runs on every accepted item
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      in_gap = 0;
      in_calm = 0;
    end else begin
      next_valid = smp_if.valid;
      if (smp_if.valid && smp_if.ready) begin
        take_sample(smp_if.kind, smp_if.sample, smp_if.last);
        items_taken++;
        next_valid = 1'b0;
        if (in_calm != 0) begin
          in_calm--;
          in_gap = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          in_calm = $urandom_range(20, 120);
          in_gap = 0;
        end else begin
          in_gap = pick_gap();
        end
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (sample_q.size() != 0 &&
                     (!sample_q[0].hold || lag_expect_q.size() == 0)) begin
          cur_item = sample_q.pop_front();
          next_valid = 1'b1;
          smp_if.kind   <= cur_item.kind;
          smp_if.sample <= cur_item.sample;
          smp_if.last   <= cur_item.last;
        end
      end
      smp_if.valid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // lag monitor and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lag_if.ready <= 1'b0;
      out_gap = 0;
      out_calm = 0;
    end else begin
      lag_taken = lag_if.valid && lag_if.ready;
      if (lag_taken) begin
        if (lag_expect_q.size() == 0) begin
          $display("%0t: unexpected lag item: lag %0d value %0d end %0b trunc %0b",
                   $time, lag_if.lag_index, lag_if.value, lag_if.end_of_run,
                   lag_if.truncated);
          errors++;
        end else begin
          want = lag_expect_q.pop_front();
          if (lag_if.lag_index !== want.lag) begin
            $display("%0t: lag_index expected %0d, got %0d",
                     $time, want.lag, lag_if.lag_index);
            errors++;
          end
          if (lag_if.value !== want.value) begin
            $display("%0t: value at lag %0d expected %0d, got %0d",
                     $time, want.lag, want.value, lag_if.value);
            errors++;
          end
          if (lag_if.end_of_run !== want.end_of_run) begin
            $display("%0t: end_of_run at lag %0d expected %0b, got %0b",
                     $time, want.lag, want.end_of_run, lag_if.end_of_run);
            errors++;
          end
          if (lag_if.truncated !== want.truncated) begin
            $display("%0t: truncated at lag %0d expected %0b, got %0b",
                     $time, want.lag, want.truncated, lag_if.truncated);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        lag_if.ready <= 1'b0;
      end else begin
        lag_if.ready <= 1'b1;
        if (lag_taken || $urandom_range(0, 19) == 0) begin
          if (out_calm != 0) begin
            out_calm--;
          end else if ($urandom_range(0, 49) == 0) begin
            out_calm = $urandom_range(20, 120);
          end else begin
            out_gap = pick_gap();
          end
        end
      end
    end
  end

  // watchdog: no item moving on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((smp_if.valid && smp_if.ready) || (lag_if.valid && lag_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d lag items outstanding",
               $time, IDLE_LIMIT, lag_expect_q.size());
      $display("full_cross_correlation test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int counted, n1, n2;
    smp_if.valid  = 1'b0;
    smp_if.kind   = KIND_FIRST;
    smp_if.sample = '0;
    smp_if.last   = 1'b0;
    lag_if.ready  = 1'b0;
    rst_ni = 1'b0;
    errors = 0;
    items_taken = 0;
    len_a = 0;
    len_b = 0;
    closed_a = 1'b0;
    closed_b = 1'b0;
    dropped = 1'b0;

    // single samples at opposite extremes: one lag
    push_item(KIND_FIRST,  16'h7FFF, 1'b1, 1'b0);
    push_item(KIND_SECOND, 16'h8000, 1'b1, 1'b0);
    // second sequence first; stray sample for the closed second is ignored
    push_item(KIND_SECOND, 16'h8000, 1'b0, 1'b1);
    push_item(KIND_SECOND, 16'h8000, 1'b1, 1'b0);
    push_item(KIND_SECOND, 16'h1234, 1'b1, 1'b0);
    push_item(KIND_FIRST,  16'h8000, 1'b0, 1'b0);
    push_item(KIND_FIRST,  16'h7FFF, 1'b1, 1'b0);
    // interleaved, stray sample for the closed first
    push_item(KIND_FIRST,  16'hFFFF, 1'b0, 1'b1);
    push_item(KIND_SECOND, 16'h0001, 1'b0, 1'b0);
    push_item(KIND_FIRST,  16'h0000, 1'b1, 1'b0);
    push_item(KIND_FIRST,  16'h5555, 1'b0, 1'b0);
    push_item(KIND_SECOND, 16'hAAAA, 1'b1, 1'b0);
    // short against longer, both ways round
    push_item(KIND_FIRST,  16'h8000, 1'b1, 1'b1);
    push_item(KIND_SECOND, 16'h7FFF, 1'b0, 1'b0);
    push_item(KIND_SECOND, 16'h4000, 1'b0, 1'b0);
    push_item(KIND_SECOND, 16'hC000, 1'b1, 1'b0);
    push_item(KIND_FIRST,  16'h0003, 1'b0, 1'b1);
    push_item(KIND_FIRST,  16'hFFFD, 1'b0, 1'b0);
    push_item(KIND_FIRST,  16'h7FFF, 1'b1, 1'b0);
    push_item(KIND_SECOND, 16'h8000, 1'b1, 1'b0);

    // full length, every term (-32768)*(-32768): the center lag saturates
    queue_pair(MAX_LEN, MAX_LEN, FILL_MIN, 1'b1);
    // overflow on both sides, closed by dropped samples
    queue_pair(MAX_LEN + 2, MAX_LEN + 1, FILL_EXTREME, 1'b1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      n1 = pick_len();
      n2 = pick_len();
      queue_pair(n1, n2, pick_fill(), $urandom_range(0, 9) == 0);
      counted += n1 + n2;
    end
    items_total = sample_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_taken == items_total);
    while (lag_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && lag_expect_q.size() == 0) begin
      $display("full_cross_correlation test passed");
    end else begin
      $display("full_cross_correlation test failed");
    end
    $finish;
  end

endmodule
